@@ hw/rtl/hck_pkg.sv @@
`timescale 1ns / 1ps

package hck_pkg;

  // channel and hue widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned HUE_W   = 8;
  localparam int unsigned H_W     = 12;  // signed sector offset, -d .. 5d
  localparam int unsigned RECIP_W = 17;  // round(122880 / d) fits 17 bits
  localparam int unsigned PROD_W  = 23;  // signed product, |p| < 2^21
  localparam int unsigned T_W     = 9;   // shifted hue before the wrap, < 512
  localparam int unsigned FRAC_W  = 12;

  localparam int unsigned RECIP_NUM = 245760;
  localparam int unsigned HUE_MOD   = 180;
  // rounding half plus one whole turn of 180 so the sum never goes negative
  localparam int unsigned HUE_OFS   = HUE_MOD * (1 << FRAC_W) + (1 << (FRAC_W - 1));

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HUE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_TOL = 1'd1;
  localparam logic [HUE_W-1:0] KEY_HUE_RST = 8'd60;
  localparam logic [HUE_W-1:0] HUE_TOL_RST = 8'd20;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t fg;
    pix_t bg;
  } pair_t;

  typedef struct packed {
    logic [HUE_W-1:0] key_hue;
    logic [HUE_W-1:0] hue_tolerance;
  } cfg_t;

endpackage

@@ hw/rtl/hck_hue.sv @@
`timescale 1ns / 1ps

module hck_hue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  hck_pkg::pair_t                pix_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [hck_pkg::HUE_W-1:0]     hue_o,
  output hck_pkg::pair_t                pix_o
);
  import hck_pkg::*;

  // reciprocal table, round(122880 / d), zero for a grey pixel
  logic [RECIP_W-1:0] recip_tbl [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_recip
    localparam int unsigned Den = (gi == 0) ? 1 : 2 * gi;
    localparam int unsigned Rv  = (gi == 0) ? 0 : (RECIP_NUM + gi) / Den;
    assign recip_tbl[gi] = RECIP_W'(Rv);
  end

  // stage valids and per-stage ready
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v5_q;

  // stage 1: max, min, sector
  pair_t            s1_pix_q, s2_pix_q, s3_pix_q, s4_pix_q, s5_pix_q;
  logic [CH_W-1:0]  s1_max_d, s1_max_q, s1_min_d, s1_min_q;
  sector_e          s1_sec_d, s1_sec_q;
  logic [CH_W-1:0]  mx_rg, mn_rg;

  always_comb begin
    mx_rg    = (pix_i.fg.red > pix_i.fg.green) ? pix_i.fg.red : pix_i.fg.green;
    mn_rg    = (pix_i.fg.red < pix_i.fg.green) ? pix_i.fg.red : pix_i.fg.green;
    s1_max_d = (mx_rg > pix_i.fg.blue) ? mx_rg : pix_i.fg.blue;
    s1_min_d = (mn_rg < pix_i.fg.blue) ? mn_rg : pix_i.fg.blue;
    if (s1_max_d == pix_i.fg.red) begin
      s1_sec_d = SEC_RED;
    end else if (s1_max_d == pix_i.fg.green) begin
      s1_sec_d = SEC_GREEN;
    end else begin
      s1_sec_d = SEC_BLUE;
    end
  end

  // stage 2: difference and sector offset
  logic [CH_W-1:0]        s2_d_d, s2_d_q;
  logic signed [H_W-1:0]  s2_h_d, s2_h_q;
  logic signed [H_W-1:0]  rs, gs, bs, ds;

  always_comb begin
    s2_d_d = s1_max_q - s1_min_q;
    rs = $signed({{(H_W - CH_W){1'b0}}, s1_pix_q.fg.red});
    gs = $signed({{(H_W - CH_W){1'b0}}, s1_pix_q.fg.green});
    bs = $signed({{(H_W - CH_W){1'b0}}, s1_pix_q.fg.blue});
    ds = $signed({{(H_W - CH_W){1'b0}}, s2_d_d});
    case (s1_sec_q)
      SEC_RED:   s2_h_d = gs - bs;
      SEC_GREEN: s2_h_d = bs - rs + (ds <<< 1);
      SEC_BLUE:  s2_h_d = rs - gs + (ds <<< 2);
      default:   s2_h_d = '0;
    endcase
  end

  // stage 3: reciprocal lookup
  logic [RECIP_W-1:0]     s3_recip_d, s3_recip_q;
  logic signed [H_W-1:0]  s3_h_q;
  assign s3_recip_d = recip_tbl[s2_d_q];

  // stage 4: multiply
  logic signed [H_W+RECIP_W:0] prod_full;
  logic signed [PROD_W-1:0]    s4_prod_d, s4_prod_q;
  assign prod_full = s3_h_q * $signed({1'b0, s3_recip_q});
  assign s4_prod_d = prod_full[PROD_W-1:0];

  // stage 5: round, scale down, wrap into 0..179
  logic signed [PROD_W-1:0] t_sum;
  logic [T_W-1:0]           t_sh;
  logic [HUE_W-1:0]         s5_hue_d, s5_hue_q;

  always_comb begin
    t_sum = s4_prod_q + $signed(PROD_W'(HUE_OFS));
    t_sh  = t_sum[FRAC_W +: T_W];
    if (t_sh >= T_W'(HUE_MOD)) begin
      s5_hue_d = HUE_W'(t_sh - T_W'(HUE_MOD));
    end else begin
      s5_hue_d = HUE_W'(t_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_pix_q <= pix_i;
      s1_max_q <= s1_max_d;
      s1_min_q <= s1_min_d;
      s1_sec_q <= s1_sec_d;
    end
    if (rdy2) begin
      s2_pix_q <= s1_pix_q;
      s2_d_q   <= s2_d_d;
      s2_h_q   <= s2_h_d;
    end
    if (rdy3) begin
      s3_pix_q   <= s2_pix_q;
      s3_recip_q <= s3_recip_d;
      s3_h_q     <= s2_h_q;
    end
    if (rdy4) begin
      s4_pix_q  <= s3_pix_q;
      s4_prod_q <= s4_prod_d;
    end
    if (rdy5) begin
      s5_pix_q <= s4_pix_q;
      s5_hue_q <= s5_hue_d;
    end
  end

  assign hue_o = s5_hue_q;
  assign pix_o = s5_pix_q;

endmodule

@@ hw/rtl/hck_key.sv @@
`timescale 1ns / 1ps

module hck_key (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hck_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [hck_pkg::HUE_W-1:0]     hue_i,
  input  hck_pkg::pair_t                pix_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output hck_pkg::pix_t                 pix_o,
  output logic                          keyed_o
);
  import hck_pkg::*;

  logic [HUE_W-1:0] lo, hi;
  logic [HUE_W:0]   hi_sum;
  logic             keyed_d, keyed_q;
  pix_t             pix_d, pix_q;
  logic             ov_q;
  logic             rdy;

  // window clipped at zero and at the top of the byte range
  always_comb begin
    lo     = (cfg_i.key_hue > cfg_i.hue_tolerance) ?
             cfg_i.key_hue - cfg_i.hue_tolerance : '0;
    hi_sum = {1'b0, cfg_i.key_hue} + {1'b0, cfg_i.hue_tolerance};
    hi     = hi_sum[HUE_W] ? {HUE_W{1'b1}} : hi_sum[HUE_W-1:0];
    keyed_d = (hue_i >= lo) && (hue_i <= hi);
    pix_d   = keyed_d ? pix_i.bg : pix_i.fg;
  end

  assign rdy     = !ov_q || !stall_i;
  assign ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy) begin
      ov_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      pix_q   <= pix_d;
      keyed_q <= keyed_d;
    end
  end

  assign valid_o = ov_q;
  assign pix_o   = pix_q;
  assign keyed_o = keyed_q;

endmodule

@@ hw/rtl/hsv_hue_chroma_key.sv @@
`timescale 1ns / 1ps

// hsv hue chroma key
// input channel: one word per pixel, foreground rgb plus the background rgb at
//   the same position; a word is taken on a rising edge with in_valid_i high
//   and in_stall_o low
// output channel: the composited rgb and keyed_out_o, taken on a rising edge
//   with out_valid_o high and out_stall_i low
// the foreground hue (0..179, half-degree units, 0 for grey) is compared with
//   the inclusive window key_hue +/- hue_tolerance, clipped to 0..255; inside
//   the window the background pixel goes out, otherwise the foreground
// an accepted word passes through five hue stages, then the key compare and
//   output register, the first stage loading at the accepting edge itself
// throughput: one word per cycle while the output is not stalled, set by the
//   six register stages each taking one word per clock; there is no state
//   carried between pixels
// a receiver stall holds the output word; each stage keeps filling while it
//   has a free slot, so in_stall_o rises only once every stage is full
// reset empties the pipeline and loads key_hue = 60, hue_tolerance = 20
// config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 key_hue,
//   1 hue_tolerance); write only while no word is in flight

module hsv_hue_chroma_key (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hck_pkg::CH_W-1:0]          fg_red_i,
  input  logic [hck_pkg::CH_W-1:0]          fg_green_i,
  input  logic [hck_pkg::CH_W-1:0]          fg_blue_i,
  input  logic [hck_pkg::CH_W-1:0]          bg_red_i,
  input  logic [hck_pkg::CH_W-1:0]          bg_green_i,
  input  logic [hck_pkg::CH_W-1:0]          bg_blue_i,
  // pixel output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hck_pkg::CH_W-1:0]          out_red_o,
  output logic [hck_pkg::CH_W-1:0]          out_green_o,
  output logic [hck_pkg::CH_W-1:0]          out_blue_o,
  output logic                              keyed_out_o,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [hck_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hck_pkg::HUE_W-1:0]         cfg_data_i
);
  import hck_pkg::*;

  // config registers
  logic [HUE_W-1:0] key_hue_q, key_hue_d;
  logic [HUE_W-1:0] hue_tol_q, hue_tol_d;
  cfg_t             cfg;

  always_comb begin
    key_hue_d = key_hue_q;
    hue_tol_d = hue_tol_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_HUE: key_hue_d = cfg_data_i;
        CFG_HUE_TOL: hue_tol_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hue_q <= KEY_HUE_RST;
      hue_tol_q <= HUE_TOL_RST;
    end else begin
      key_hue_q <= key_hue_d;
      hue_tol_q <= hue_tol_d;
    end
  end

  assign cfg.key_hue       = key_hue_q;
  assign cfg.hue_tolerance = hue_tol_q;

  // input word packing
  pair_t in_pix;
  assign in_pix.fg.red   = fg_red_i;
  assign in_pix.fg.green = fg_green_i;
  assign in_pix.fg.blue  = fg_blue_i;
  assign in_pix.bg.red   = bg_red_i;
  assign in_pix.bg.green = bg_green_i;
  assign in_pix.bg.blue  = bg_blue_i;

  // hue pipeline
  logic             in_ready;
  logic             hue_valid;
  logic             key_ready;
  logic [HUE_W-1:0] hue;
  pair_t            hue_pix;

  hck_hue u_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .pix_i   (in_pix),
    .valid_o (hue_valid),
    .ready_i (key_ready),
    .hue_o   (hue),
    .pix_o   (hue_pix)
  );

  assign in_stall_o = !in_ready;

  // window compare, select and output register
  pix_t out_pix;

  hck_key u_key (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (hue_valid),
    .ready_o (key_ready),
    .hue_i   (hue),
    .pix_i   (hue_pix),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .pix_o   (out_pix),
    .keyed_o (keyed_out_o)
  );

  assign out_red_o   = out_pix.red;
  assign out_green_o = out_pix.green;
  assign out_blue_o  = out_pix.blue;

  // input backs up only when the whole pipe is full behind a stalled output
  a_stall_needs_full_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)
  ) else $error("input stalled without a stalled output word");

  // the wrapped hue never leaves 0..179
  a_hue_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    hue_valid |-> (hue < HUE_W'(HUE_MOD))
  ) else $error("hue out of range");

  // a word that reaches the key stage while it is free shows up on the next edge
  a_key_handoff: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (hue_valid && key_ready) |=> out_valid_o
  ) else $error("hue word lost at the key stage");

endmodule
